// ===== hw/rtl/ctl_pkg.sv =====
package ctl_pkg;

  // Token kinds on the result channel
  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_NEWLINE = 4'd1;
  localparam logic [3:0] KIND_CALL    = 4'd2;
  localparam logic [3:0] KIND_MEMBER  = 4'd3;
  localparam logic [3:0] KIND_INDEX   = 4'd4;
  localparam logic [3:0] KIND_OR      = 4'd5;
  localparam logic [3:0] KIND_AND     = 4'd6;
  localparam logic [3:0] KIND_CMP     = 4'd7;
  localparam logic [3:0] KIND_OPTIONS = 4'd8;
  localparam logic [3:0] KIND_ELSE    = 4'd9;

  localparam int unsigned MASK_W      = 10;
  localparam int unsigned RECOVER_BIT = 9;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned LETTER_W    = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [CP_W-1:0] CP_END    = 21'h00;
  localparam logic [CP_W-1:0] CP_TAB    = 21'h09;
  localparam logic [CP_W-1:0] CP_NL     = 21'h0A;
  localparam logic [CP_W-1:0] CP_CR     = 21'h0D;
  localparam logic [CP_W-1:0] CP_SPACE  = 21'h20;
  localparam logic [CP_W-1:0] CP_BANG   = 21'h21;
  localparam logic [CP_W-1:0] CP_LPAREN = 21'h28;
  localparam logic [CP_W-1:0] CP_COMMA  = 21'h2C;
  localparam logic [CP_W-1:0] CP_DOT    = 21'h2E;
  localparam logic [CP_W-1:0] CP_SLASH  = 21'h2F;
  localparam logic [CP_W-1:0] CP_DIG0   = 21'h30;
  localparam logic [CP_W-1:0] CP_DIG9   = 21'h39;
  localparam logic [CP_W-1:0] CP_LT     = 21'h3C;
  localparam logic [CP_W-1:0] CP_EQ     = 21'h3D;
  localparam logic [CP_W-1:0] CP_GT     = 21'h3E;
  localparam logic [CP_W-1:0] CP_UPA    = 21'h41;
  localparam logic [CP_W-1:0] CP_UPZ    = 21'h5A;
  localparam logic [CP_W-1:0] CP_LBRACK = 21'h5B;
  localparam logic [CP_W-1:0] CP_UNDER  = 21'h5F;
  localparam logic [CP_W-1:0] CP_LOA    = 21'h61;
  localparam logic [CP_W-1:0] CP_LOZ    = 21'h7A;
  localparam logic [CP_W-1:0] CP_LBRACE = 21'h7B;

  // Letters of the keywords
  localparam logic [LETTER_W-1:0] LT_A = 7'h61;
  localparam logic [LETTER_W-1:0] LT_D = 7'h64;
  localparam logic [LETTER_W-1:0] LT_E = 7'h65;
  localparam logic [LETTER_W-1:0] LT_L = 7'h6C;
  localparam logic [LETTER_W-1:0] LT_N = 7'h6E;
  localparam logic [LETTER_W-1:0] LT_O = 7'h6F;
  localparam logic [LETTER_W-1:0] LT_R = 7'h72;
  localparam logic [LETTER_W-1:0] LT_S = 7'h73;

  typedef enum logic [3:0] {
    CLS_END,
    CLS_NEWLINE,
    CLS_BLANK,
    CLS_SLASH,
    CLS_DOT,
    CLS_BRACKET,
    CLS_PAREN,
    CLS_CMP,
    CLS_BRACE,
    CLS_EQ,
    CLS_COMMA,
    CLS_LOWER,
    CLS_IDENT,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    logic                start;
    logic [MASK_W-1:0]   mask;
    char_class_e         cls;
    logic [LETTER_W-1:0] letter;
  } item_t;

  // Keep the found token if allowed, otherwise fall back to newline
  function automatic logic [3:0] finish_kind(logic [3:0] cand, logic nl_seen,
                                             logic [MASK_W-1:0] mask);
    logic [MASK_W-1:0] sh;
    logic [3:0]        kind;
    sh   = mask >> (cand - 4'd1);
    kind = KIND_NONE;
    if (cand != KIND_NONE && sh[0]) begin
      kind = cand;
    end else if (nl_seen && mask[0]) begin
      kind = KIND_NEWLINE;
    end
    return kind;
  endfunction

endpackage

// ===== hw/rtl/ctl_front.sv =====
module ctl_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        scan_start_i,
  input  logic [ctl_pkg::MASK_W-1:0]  allowed_mask_i,
  input  logic [ctl_pkg::CP_W-1:0]    code_point_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output ctl_pkg::item_t              item_o
);

  ctl_pkg::char_class_e cls;

  always_comb begin
    if (code_point_i == ctl_pkg::CP_END) begin
      cls = ctl_pkg::CLS_END;
    end else if (code_point_i == ctl_pkg::CP_NL) begin
      cls = ctl_pkg::CLS_NEWLINE;
    end else if (code_point_i == ctl_pkg::CP_SPACE || code_point_i == ctl_pkg::CP_TAB ||
                 code_point_i == ctl_pkg::CP_CR) begin
      cls = ctl_pkg::CLS_BLANK;
    end else if (code_point_i == ctl_pkg::CP_SLASH) begin
      cls = ctl_pkg::CLS_SLASH;
    end else if (code_point_i == ctl_pkg::CP_DOT) begin
      cls = ctl_pkg::CLS_DOT;
    end else if (code_point_i == ctl_pkg::CP_LBRACK) begin
      cls = ctl_pkg::CLS_BRACKET;
    end else if (code_point_i == ctl_pkg::CP_LPAREN) begin
      cls = ctl_pkg::CLS_PAREN;
    end else if (code_point_i == ctl_pkg::CP_LT || code_point_i == ctl_pkg::CP_GT ||
                 code_point_i == ctl_pkg::CP_BANG) begin
      cls = ctl_pkg::CLS_CMP;
    end else if (code_point_i == ctl_pkg::CP_LBRACE) begin
      cls = ctl_pkg::CLS_BRACE;
    end else if (code_point_i == ctl_pkg::CP_EQ) begin
      cls = ctl_pkg::CLS_EQ;
    end else if (code_point_i == ctl_pkg::CP_COMMA) begin
      cls = ctl_pkg::CLS_COMMA;
    end else if (code_point_i inside {[ctl_pkg::CP_LOA:ctl_pkg::CP_LOZ]}) begin
      cls = ctl_pkg::CLS_LOWER;
    end else if (code_point_i inside {[ctl_pkg::CP_UPA:ctl_pkg::CP_UPZ],
                                      [ctl_pkg::CP_DIG0:ctl_pkg::CP_DIG9],
                                      ctl_pkg::CP_UNDER}) begin
      cls = ctl_pkg::CLS_IDENT;
    end else begin
      cls = ctl_pkg::CLS_OTHER;
    end
  end

  assign in_ready_o    = !q_full_i;
  assign push_o        = in_valid_i && !q_full_i;
  assign item_o.start  = scan_start_i;
  assign item_o.mask   = allowed_mask_i;
  assign item_o.cls    = cls;
  assign item_o.letter = code_point_i[ctl_pkg::LETTER_W-1:0];

endmodule

// ===== hw/rtl/ctl_fifo.sv =====
module ctl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ctl_pkg::item_t item_i,
  input  logic           pop_i,
  output ctl_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(ctl_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(ctl_pkg::QUEUE_DEPTH + 1);

  ctl_pkg::item_t slot_q [ctl_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(ctl_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(ctl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(ctl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");

endmodule

// ===== hw/rtl/ctl_back.sv =====
module ctl_back #(
  parameter int unsigned WORD_LIMIT = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ctl_pkg::item_t item_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [3:0]     token_kind_o
);

  localparam int unsigned LenW = $clog2(WORD_LIMIT + 1);
  localparam int unsigned IdxW = $clog2(WORD_LIMIT);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_GAP     = 3'd1;
  localparam logic [2:0] PH_SLASH   = 3'd2;
  localparam logic [2:0] PH_COMMENT = 3'd3;
  localparam logic [2:0] PH_EQ      = 3'd4;
  localparam logic [2:0] PH_WORD    = 3'd5;

  logic [2:0]                   phase_q, phase_d, e_phase;
  logic                         nl_q, nl_d, e_nl;
  logic [ctl_pkg::MASK_W-1:0]   mask_q, mask_d, e_mask;
  logic [LenW-1:0]              len_q, len_d, e_len;
  logic [ctl_pkg::LETTER_W-1:0] letters_q [WORD_LIMIT];
  logic                         let_we;
  logic [IdxW-1:0]              let_idx;
  logic                         out_valid_q;
  logic [3:0]                   token_q;
  logic                         emit;
  logic [3:0]                   kind;
  logic                         gap_go, boundary, is_else, is_and, is_or;
  logic [3:0]                   cand;

  // Pop whenever the output register is free or being drained
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  assign is_else = (len_q == LenW'(4)) && letters_q[0] == ctl_pkg::LT_E &&
                   letters_q[1] == ctl_pkg::LT_L && letters_q[2] == ctl_pkg::LT_S &&
                   letters_q[3] == ctl_pkg::LT_E;
  assign is_and  = (len_q == LenW'(3)) && letters_q[0] == ctl_pkg::LT_A &&
                   letters_q[1] == ctl_pkg::LT_N && letters_q[2] == ctl_pkg::LT_D;
  assign is_or   = (len_q == LenW'(2)) && letters_q[0] == ctl_pkg::LT_O &&
                   letters_q[1] == ctl_pkg::LT_R;
  assign boundary = (item_i.cls != ctl_pkg::CLS_LOWER) &&
                    (item_i.cls != ctl_pkg::CLS_IDENT);

  always_comb begin
    e_phase = item_i.start ? PH_GAP : phase_q;
    e_nl    = item_i.start ? 1'b0 : nl_q;
    e_mask  = item_i.start ? item_i.mask : mask_q;
    e_len   = item_i.start ? '0 : len_q;
    gap_go  = (e_phase == PH_GAP) ||
              (e_phase == PH_COMMENT && (item_i.cls == ctl_pkg::CLS_END ||
                                         item_i.cls == ctl_pkg::CLS_NEWLINE));
    cand    = ctl_pkg::KIND_NONE;
    if (is_else && boundary && e_mask[ctl_pkg::KIND_ELSE - 4'd1]) begin
      cand = ctl_pkg::KIND_ELSE;
    end else if (is_and && boundary) begin
      cand = ctl_pkg::KIND_AND;
    end else if (is_or && boundary) begin
      cand = ctl_pkg::KIND_OR;
    end

    phase_d = phase_q;
    nl_d    = nl_q;
    mask_d  = mask_q;
    len_d   = len_q;
    let_we  = 1'b0;
    let_idx = '0;
    emit    = 1'b0;
    kind    = ctl_pkg::KIND_NONE;

    if (pop_o) begin
      mask_d  = e_mask;
      nl_d    = e_nl;
      len_d   = e_len;
      phase_d = e_phase;
      if (item_i.start && item_i.mask[ctl_pkg::RECOVER_BIT]) begin
        // Error recovery: fail at once
        emit    = 1'b1;
        phase_d = PH_IDLE;
      end else if (gap_go) begin
        case (item_i.cls)
          ctl_pkg::CLS_BLANK: phase_d = PH_GAP;
          ctl_pkg::CLS_NEWLINE: begin
            nl_d    = 1'b1;
            phase_d = PH_GAP;
          end
          ctl_pkg::CLS_SLASH: phase_d = PH_SLASH;
          ctl_pkg::CLS_EQ: phase_d = PH_EQ;
          ctl_pkg::CLS_LOWER: begin
            let_we  = 1'b1;
            len_d   = LenW'(1);
            phase_d = PH_WORD;
          end
          ctl_pkg::CLS_COMMA: begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
          ctl_pkg::CLS_DOT: begin
            emit = 1'b1;
            kind = ctl_pkg::finish_kind(ctl_pkg::KIND_MEMBER, e_nl, e_mask);
          end
          ctl_pkg::CLS_BRACKET: begin
            emit = 1'b1;
            kind = ctl_pkg::finish_kind(ctl_pkg::KIND_INDEX, e_nl, e_mask);
          end
          ctl_pkg::CLS_PAREN: begin
            emit = 1'b1;
            kind = ctl_pkg::finish_kind(ctl_pkg::KIND_CALL, e_nl, e_mask);
          end
          ctl_pkg::CLS_CMP: begin
            emit = 1'b1;
            kind = ctl_pkg::finish_kind(ctl_pkg::KIND_CMP, e_nl, e_mask);
          end
          ctl_pkg::CLS_BRACE: begin
            emit = 1'b1;
            kind = ctl_pkg::finish_kind(ctl_pkg::KIND_OPTIONS, e_nl, e_mask);
          end
          default: begin
            emit = 1'b1;
            kind = ctl_pkg::finish_kind(ctl_pkg::KIND_NONE, e_nl, e_mask);
          end
        endcase
        if (emit) begin
          phase_d = PH_IDLE;
        end
      end else begin
        case (e_phase)
          PH_SLASH: begin
            if (item_i.cls == ctl_pkg::CLS_SLASH) begin
              phase_d = PH_COMMENT;
            end else begin
              // Lone slash fails the scan
              emit    = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          PH_COMMENT: phase_d = PH_COMMENT;
          PH_EQ: begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
            kind    = ctl_pkg::finish_kind((item_i.cls == ctl_pkg::CLS_EQ) ?
                                           ctl_pkg::KIND_CMP : ctl_pkg::KIND_NONE,
                                           e_nl, e_mask);
          end
          PH_WORD: begin
            if (item_i.cls == ctl_pkg::CLS_LOWER && len_q < LenW'(WORD_LIMIT)) begin
              let_we  = 1'b1;
              let_idx = len_q[IdxW-1:0];
              len_d   = len_q + 1'b1;
            end else begin
              emit    = 1'b1;
              phase_d = PH_IDLE;
              kind    = ctl_pkg::finish_kind(cand, e_nl, e_mask);
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      nl_q        <= 1'b0;
      mask_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      token_q     <= ctl_pkg::KIND_NONE;
    end else begin
      phase_q <= phase_d;
      nl_q    <= nl_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        token_q     <= kind;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (let_we) begin
      letters_q[let_idx] <= item_i.letter;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = token_q;

  a_recover_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.start && item_i.mask[ctl_pkg::RECOVER_BIT])
    |=> (out_valid_q && token_q == ctl_pkg::KIND_NONE))
    else $error("error recovery did not fail the scan");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !pop_o)
    else $error("transaction popped while result stalled");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(WORD_LIMIT)) else $error("word length beyond limit");

  a_result_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> phase_q == PH_IDLE) else $error("scan still running after result");

endmodule

// ===== hw/rtl/continuation_token_lookahead_top.sv =====
// Channel  | Signals                                             | Direction
// ---------+-----------------------------------------------------+----------
// input    | in_valid_i, in_ready_o, scan_start_i,               | in
//          | allowed_mask_i, code_point_i                        |
// result   | out_valid_o, out_ready_i, token_kind_o              | out
//
// One character a cycle sustained while the result side does not stall; the deciding
// character is written into a queue slot, and its result then into the output register.
// The classifier and a two-entry queue take a character whenever the queue
// has room; the scan engine pops one entry a cycle while the output register
// is free or draining. Reset clears the queue, the scan state and the output.
// A stall on the result side fills the queue and then drops in_ready_o.
module continuation_token_lookahead_top #(
  parameter int unsigned WORD_LIMIT = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        scan_start_i,
  input  logic [ctl_pkg::MASK_W-1:0]  allowed_mask_i,
  input  logic [ctl_pkg::CP_W-1:0]    code_point_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  token_kind_o
);

  ctl_pkg::item_t push_item, head_item;
  logic           push, pop, q_full, q_empty;

  ctl_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .scan_start_i   (scan_start_i),
    .allowed_mask_i (allowed_mask_i),
    .code_point_i   (code_point_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .item_o         (push_item)
  );

  ctl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ctl_back #(
    .WORD_LIMIT (WORD_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .token_kind_o (token_kind_o)
  );

endmodule

// ===== sim/tb_continuation_token_lookahead_top.sv =====
`timescale 1ns / 100ps

module tb_continuation_token_lookahead_top;

  localparam int unsigned WORD_LIMIT   = 5;
  localparam int unsigned NUM_ITEMS    = 1050;
  localparam int unsigned QUIET_AFTER  = 900;
  localparam int unsigned PAUSE_AT     = 500;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef logic [ctl_pkg::CP_W-1:0]     cp_t;
  typedef logic [ctl_pkg::MASK_W-1:0]   mask_t;
  typedef logic [ctl_pkg::LETTER_W-1:0] letter_t;

  localparam mask_t MASK_ALL     = 10'h1FF;
  localparam mask_t MASK_NEWLINE = 10'h001;
  localparam mask_t MASK_RECOVER = 10'h3FF;
  localparam cp_t   CP_MAX       = 21'h1FFFFF;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_GAP,
    SCAN_SLASH,
    SCAN_COMMENT,
    SCAN_EQ,
    SCAN_WORD
  } scan_phase_e;

  // Tracks the scan state and holds the token kinds still to come out
  class lookahead_tracker;
    logic [3:0]  pending_kinds[$];
    int          errors;
    scan_phase_e phase;
    bit          nl_seen;
    mask_t       mask;
    letter_t     letters[WORD_LIMIT];
    int          wlen;
    cp_t         first_cp;

    function new();
      errors   = 0;
      phase    = SCAN_IDLE;
      nl_seen  = 1'b0;
      mask     = '0;
      wlen     = 0;
      first_cp = '0;
      foreach (letters[i]) letters[i] = '0;
    endfunction

    function int pending();
      return pending_kinds.size();
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    function bit is_lower(cp_t c);
      return c >= ctl_pkg::CP_LOA && c <= ctl_pkg::CP_LOZ;
    endfunction

    function bit is_ident(cp_t c);
      return is_lower(c) || (c >= ctl_pkg::CP_UPA && c <= ctl_pkg::CP_UPZ) ||
             (c >= ctl_pkg::CP_DIG0 && c <= ctl_pkg::CP_DIG9) || c == ctl_pkg::CP_UNDER;
    endfunction

    function bit spells(string w);
      byte ch;
      if (wlen != w.len()) return 1'b0;
      for (int i = 0; i < wlen; i++) begin
        ch = w[i];
        if (letters[i] != ch[ctl_pkg::LETTER_W-1:0]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Close the scan: keep an allowed token, else fall back to newline
    function logic [3:0] settle(logic [3:0] cand);
      int idx;
      idx   = int'(cand) - 1;
      phase = SCAN_IDLE;
      if (cand != ctl_pkg::KIND_NONE && mask[idx]) return cand;
      if (first_cp == ctl_pkg::CP_COMMA) return ctl_pkg::KIND_NONE;
      if (nl_seen && mask[ctl_pkg::KIND_NEWLINE-1]) return ctl_pkg::KIND_NEWLINE;
      return ctl_pkg::KIND_NONE;
    endfunction

    function bit take_gap(cp_t c, output logic [3:0] kind);
      kind = ctl_pkg::KIND_NONE;
      if (c == ctl_pkg::CP_SPACE || c == ctl_pkg::CP_TAB || c == ctl_pkg::CP_CR ||
          c == ctl_pkg::CP_NL) begin
        if (c == ctl_pkg::CP_NL) nl_seen = 1'b1;
        phase = SCAN_GAP;
        return 1'b0;
      end
      if (c == ctl_pkg::CP_SLASH) begin
        phase = SCAN_SLASH;
        return 1'b0;
      end
      first_cp = c;
      case (c)
        ctl_pkg::CP_DOT:    kind = settle(ctl_pkg::KIND_MEMBER);
        ctl_pkg::CP_LBRACK: kind = settle(ctl_pkg::KIND_INDEX);
        ctl_pkg::CP_LPAREN: kind = settle(ctl_pkg::KIND_CALL);
        ctl_pkg::CP_LT, ctl_pkg::CP_GT, ctl_pkg::CP_BANG: kind = settle(ctl_pkg::KIND_CMP);
        ctl_pkg::CP_LBRACE: kind = settle(ctl_pkg::KIND_OPTIONS);
        ctl_pkg::CP_EQ: begin
          phase = SCAN_EQ;
          return 1'b0;
        end
        default: begin
          if (!is_lower(c)) begin
            kind = settle(ctl_pkg::KIND_NONE);
            return 1'b1;
          end
          foreach (letters[i]) letters[i] = '0;
          letters[0] = c[ctl_pkg::LETTER_W-1:0];
          wlen       = 1;
          phase      = SCAN_WORD;
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    function void note_char(bit start, mask_t m, cp_t c);
      bit         done;
      logic [3:0] kind;
      logic [3:0] cand;
      bit         boundary;
      done = 1'b0;
      kind = ctl_pkg::KIND_NONE;
      if (start) begin
        mask     = m;
        nl_seen  = 1'b0;
        wlen     = 0;
        first_cp = '0;
        foreach (letters[i]) letters[i] = '0;
        // error recovery fails the scan straight away
        if (m[ctl_pkg::RECOVER_BIT]) begin
          phase = SCAN_IDLE;
          pending_kinds.push_back(ctl_pkg::KIND_NONE);
          return;
        end
        phase = SCAN_GAP;
      end
      case (phase)
        SCAN_GAP: done = take_gap(c, kind);
        SCAN_SLASH: begin
          if (c == ctl_pkg::CP_SLASH) begin
            phase = SCAN_COMMENT;
          end else begin
            phase = SCAN_IDLE;
            done  = 1'b1;
          end
        end
        SCAN_COMMENT: begin
          if (c == ctl_pkg::CP_END || c == ctl_pkg::CP_NL) done = take_gap(c, kind);
        end
        SCAN_EQ: begin
          kind = settle(c == ctl_pkg::CP_EQ ? ctl_pkg::KIND_CMP : ctl_pkg::KIND_NONE);
          done = 1'b1;
        end
        SCAN_WORD: begin
          if (is_lower(c) && wlen < WORD_LIMIT) begin
            letters[wlen] = c[ctl_pkg::LETTER_W-1:0];
            wlen++;
          end else begin
            boundary = !is_ident(c);
            cand     = ctl_pkg::KIND_NONE;
            if (boundary && spells("else") && mask[ctl_pkg::KIND_ELSE-1]) begin
              cand = ctl_pkg::KIND_ELSE;
            end else if (boundary && spells("and")) begin
              cand = ctl_pkg::KIND_AND;
            end else if (boundary && spells("or")) begin
              cand = ctl_pkg::KIND_OR;
            end
            kind = settle(cand);
            done = 1'b1;
          end
        end
        default: phase = SCAN_IDLE;
      endcase
      if (done) pending_kinds.push_back(kind);
    endfunction

    task check_token(logic [3:0] kind);
      logic [3:0] want;
      if (pending_kinds.size() == 0) begin
        report($sformatf("token_kind %0d with no result pending", kind));
      end else begin
        want = pending_kinds.pop_front();
        if (kind !== want) report($sformatf("token_kind got %0d, want %0d", kind, want));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       scan_start_i;
  mask_t      allowed_mask_i;
  cp_t        code_point_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [3:0] token_kind_o;

  lookahead_tracker sb;
  bit               gaps_on;
  bit               stalls_on;
  int unsigned      scan_items;
  cp_t              scan_codes[$];

  continuation_token_lookahead_top #(
    .WORD_LIMIT(WORD_LIMIT)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .scan_start_i  (scan_start_i),
    .allowed_mask_i(allowed_mask_i),
    .code_point_i  (code_point_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic cp_t any_code();
    case ($urandom_range(0, 3))
      0:       return cp_t'($urandom);
      1:       return cp_t'($urandom_range(0, 1114111));
      default: return cp_t'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic mask_t any_mask();
    mask_t m;
    case ($urandom_range(0, 15))
      0: m = MASK_RECOVER;
      1: m = MASK_ALL;
      2: m = '0;
      default: begin
        m = mask_t'($urandom);
        m[ctl_pkg::RECOVER_BIT] = ($urandom_range(0, 11) == 0);
      end
    endcase
    return m;
  endfunction

  // Drive one transaction and hold it until the block takes it
  task automatic send_char(bit start, mask_t m, cp_t cp);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    scan_start_i   <= start;
    allowed_mask_i <= m;
    code_point_i   <= cp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_char(start, m, cp);
  endtask

  task automatic send_text(string s, mask_t m);
    cp_t cp;
    for (int i = 0; i < s.len(); i++) begin
      cp = cp_t'(s[i]);
      send_char(i == 0, m, cp);
    end
  endtask

  task automatic add_gap();
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0:    scan_codes.push_back(ctl_pkg::CP_SPACE);
        1:    scan_codes.push_back(ctl_pkg::CP_TAB);
        2:    scan_codes.push_back(ctl_pkg::CP_CR);
        3, 4: scan_codes.push_back(ctl_pkg::CP_NL);
        default: begin
          scan_codes.push_back(ctl_pkg::CP_SLASH);
          scan_codes.push_back(ctl_pkg::CP_SLASH);
          repeat ($urandom_range(0, 3)) scan_codes.push_back(cp_t'($urandom_range(32, 126)));
          scan_codes.push_back($urandom_range(0, 5) == 0 ? ctl_pkg::CP_END : ctl_pkg::CP_NL);
        end
      endcase
    end
  endtask

  task automatic add_word_end();
    case ($urandom_range(0, 9))
      0: scan_codes.push_back(ctl_pkg::CP_SPACE);
      1: scan_codes.push_back(ctl_pkg::CP_NL);
      2: scan_codes.push_back(ctl_pkg::CP_LPAREN);
      3: scan_codes.push_back(ctl_pkg::CP_END);
      4: scan_codes.push_back(ctl_pkg::CP_DOT);
      5: scan_codes.push_back(any_code());
      6: scan_codes.push_back(cp_t'($urandom_range(ctl_pkg::CP_UPA, ctl_pkg::CP_UPZ)));
      7: scan_codes.push_back(cp_t'($urandom_range(ctl_pkg::CP_DIG0, ctl_pkg::CP_DIG9)));
      8: scan_codes.push_back(ctl_pkg::CP_UNDER);
      default: scan_codes.push_back(cp_t'($urandom_range(ctl_pkg::CP_LOA, ctl_pkg::CP_LOZ)));
    endcase
  endtask

  task automatic add_lookahead();
    string word;
    cp_t   cp;
    case ($urandom_range(0, 15))
      0: scan_codes.push_back(ctl_pkg::CP_DOT);
      1: scan_codes.push_back(ctl_pkg::CP_LBRACK);
      2: scan_codes.push_back(ctl_pkg::CP_LPAREN);
      3: scan_codes.push_back(ctl_pkg::CP_LT);
      4: scan_codes.push_back(ctl_pkg::CP_GT);
      5: scan_codes.push_back(ctl_pkg::CP_BANG);
      6: scan_codes.push_back(ctl_pkg::CP_LBRACE);
      7: begin
        scan_codes.push_back(ctl_pkg::CP_EQ);
        scan_codes.push_back($urandom_range(0, 2) != 0 ? ctl_pkg::CP_EQ : any_code());
      end
      8, 9, 10: begin
        case ($urandom_range(0, 2))
          0:       word = "else";
          1:       word = "and";
          default: word = "or";
        endcase
        // now and then clip or stretch the keyword so it misses
        case ($urandom_range(0, 9))
          0:       word = word.substr(0, word.len() - 2);
          1:       word = {word, "s"};
          default: ;
        endcase
        for (int i = 0; i < word.len(); i++) begin
          cp = cp_t'(word[i]);
          scan_codes.push_back(cp);
        end
        add_word_end();
      end
      11: begin
        repeat ($urandom_range(1, 7)) begin
          scan_codes.push_back(cp_t'($urandom_range(ctl_pkg::CP_LOA, ctl_pkg::CP_LOZ)));
        end
        add_word_end();
      end
      12: scan_codes.push_back(ctl_pkg::CP_COMMA);
      13: scan_codes.push_back(ctl_pkg::CP_END);
      14: begin
        cp = any_code();
        scan_codes.push_back(ctl_pkg::CP_SLASH);
        scan_codes.push_back(cp == ctl_pkg::CP_SLASH ? ctl_pkg::CP_END : cp);
      end
      default: scan_codes.push_back(any_code());
    endcase
  endtask

  task automatic run_scan();
    int unsigned keep;
    scan_codes.delete();
    add_gap();
    add_lookahead();
    // cut the scan short so that the next start drops it
    if ($urandom_range(0, 11) == 0 && scan_codes.size() > 1) begin
      keep = $urandom_range(1, scan_codes.size() - 1);
      while (scan_codes.size() > keep) void'(scan_codes.pop_back());
    end
    foreach (scan_codes[i]) begin
      send_char(i == 0, i == 0 ? any_mask() : mask_t'($urandom), scan_codes[i]);
      scan_items++;
    end
    repeat ($urandom_range(0, 2)) begin
      send_char(1'b0, mask_t'($urandom), any_code());
      scan_items++;
    end
  endtask

  // Result side: check every accepted token and stall in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_token(token_kind_o);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL continuation_token_lookahead_top");
    $finish;
  end

  initial begin
    bit paused;
    sb             = new();
    paused         = 1'b0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    scan_items     = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    scan_start_i   = 1'b0;
    allowed_mask_i = '0;
    code_point_i   = '0;
    out_ready_i    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(".", MASK_ALL);
    send_text("[", MASK_ALL);
    send_text("(", MASK_ALL);
    send_text("!", MASK_ALL);
    send_text("\t\n{", MASK_NEWLINE);
    send_text("==", MASK_ALL);
    send_text("else ", MASK_ALL);
    send_text("and(", MASK_ALL);
    send_text("or", MASK_ALL);
    send_char(1'b0, MASK_ALL, ctl_pkg::CP_END);
    send_char(1'b1, MASK_RECOVER, ctl_pkg::CP_DOT);
    send_text("/x", MASK_ALL);
    send_text("//\n,", MASK_ALL);
    send_char(1'b1, MASK_ALL, CP_MAX);
    // no scan open: ignored
    send_char(1'b0, MASK_ALL, ctl_pkg::CP_DOT);

    while (scan_items < NUM_ITEMS) begin
      if (scan_items >= QUIET_AFTER) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      // once, hold the input side until every token has come out
      if (!paused && scan_items >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      run_scan();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS continuation_token_lookahead_top");
    end else begin
      $display("FAIL continuation_token_lookahead_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_front.sv
hw/rtl/ctl_fifo.sv
hw/rtl/ctl_back.sv
hw/rtl/continuation_token_lookahead_top.sv
sim/tb_continuation_token_lookahead_top.sv
